// File: rtl/ljpf_pkg.sv
package ljpf_pkg;

   // Default sizes of the atom and type tables.
   localparam int NUM_ATOMS_DEF = 1024;
   localparam int NUM_TYPES_DEF = 4;
   localparam int NCOEF         = 6;

   // Stream widths.
   localparam int REQ_DATA_W = 208;
   localparam int RSP_DATA_W = 256;

   // Command codes carried in req_tuser.
   localparam logic [1:0] CMD_PAIR = 2'd0;
   localparam logic [1:0] CMD_READ = 2'd1;
   localparam logic [1:0] CMD_LOAD = 2'd2;

   // Coefficient selectors.
   localparam logic [2:0] CSEL_LJ1   = 3'd0;
   localparam logic [2:0] CSEL_LJ2   = 3'd1;
   localparam logic [2:0] CSEL_LJ3   = 3'd2;
   localparam logic [2:0] CSEL_LJ4   = 3'd3;
   localparam logic [2:0] CSEL_OFFS  = 3'd4;
   localparam logic [2:0] CSEL_CUTSQ = 3'd5;

   // Q32.32 limits.
   localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;

   // Reciprocal: quotient bits and the divisor at or below which the result saturates.
   localparam int          RECIP_STEPS = 81;
   localparam logic [63:0] RECIP_LIM   = 64'h0000_0000_0002_0000;

   // Magnitude of a signed word; the most negative value maps to 2^63.
   function automatic logic [63:0] mag64(input logic signed [63:0] a);
      return a[63] ? (64'd0 - a) : a;
   endfunction

   // Saturating add.
   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
      return s[63:0];
   endfunction

   // Saturating subtract.
   function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
      return s[63:0];
   endfunction

endpackage

// File: rtl/lj_pair_force_accumulator.sv
// Channel   Direction  Handshake                  Payload
// req       in         req_tvalid / req_tready    req_tdata, req_tuser (command)
// rsp       out        rsp_tvalid / rsp_tready    rsp_tdata, rsp_tuser (in_range)
// csr       in         csr_valid / csr_ready      csr_data (energy_enable)
//
// A pair inside the cutoff runs coefficient reads, 15 products on the shared 32x32 multiplier,
// the cutoff test, the bit-serial reciprocal (saturating without its steps for a tiny
// distance), the accumulator read-modify-write of atom i and, with update_j, atom j, and the
// result load. With energy off only 12 products run. A pair outside the cutoff stops after the
// three distance products and the cutoff test; a read runs an accumulator read and write; a
// load or an unused command only loads the result. After reset a clearing pass zeroes all
// NUM_ATOMS accumulator entries; no item is accepted meanwhile. The result waits in an output
// register while rsp stalls, and the sequencer holds until that register is free.
module lj_pair_force_accumulator #(
   parameter int NUM_ATOMS = ljpf_pkg::NUM_ATOMS_DEF,
   parameter int NUM_TYPES = ljpf_pkg::NUM_TYPES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // atom_i, atom_j, type_i, type_j, update_j, delx, dely, delz, special_scale,
   // coeff_select, coeff_value, zero pad
   input  logic [ljpf_pkg::REQ_DATA_W-1:0] req_tdata,
   // command
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // force_x, force_y, force_z, energy
   output logic [ljpf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // in_range
   output logic [0:0]                      rsp_tuser,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [0:0]                      csr_data
);
   import ljpf_pkg::*;

   localparam int AW     = $clog2(NUM_ATOMS);
   localparam int CDEPTH = NUM_TYPES * NUM_TYPES * NCOEF;
   localparam int CAW    = $clog2(CDEPTH);

   // Sequencer states.
   localparam logic [3:0] ST_CLEAR   = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_COEF    = 4'd2;
   localparam logic [3:0] ST_MUL     = 4'd3;
   localparam logic [3:0] ST_MWAIT   = 4'd4;
   localparam logic [3:0] ST_CHECK   = 4'd5;
   localparam logic [3:0] ST_DWAIT   = 4'd6;
   localparam logic [3:0] ST_ACC_RD  = 4'd7;
   localparam logic [3:0] ST_ACC_WR  = 4'd8;
   localparam logic [3:0] ST_READ_RD = 4'd9;
   localparam logic [3:0] ST_READ_WR = 4'd10;
   localparam logic [3:0] ST_DONE    = 4'd11;

   // Product steps.
   localparam logic [3:0] OP_RSQ_X = 4'd0;
   localparam logic [3:0] OP_RSQ_Y = 4'd1;
   localparam logic [3:0] OP_RSQ_Z = 4'd2;
   localparam logic [3:0] OP_R4    = 4'd3;
   localparam logic [3:0] OP_R6    = 4'd4;
   localparam logic [3:0] OP_F1    = 4'd5;
   localparam logic [3:0] OP_FLJ   = 4'd6;
   localparam logic [3:0] OP_FFAC  = 4'd7;
   localparam logic [3:0] OP_FP    = 4'd8;
   localparam logic [3:0] OP_PX    = 4'd9;
   localparam logic [3:0] OP_PY    = 4'd10;
   localparam logic [3:0] OP_PZ    = 4'd11;
   localparam logic [3:0] OP_E1    = 4'd12;
   localparam logic [3:0] OP_E2    = 4'd13;
   localparam logic [3:0] OP_EFAC  = 4'd14;

   // Coefficient base address of a type pair.
   function automatic logic [CAW-1:0] coef_base(input logic [1:0] ti, input logic [1:0] tj);
      return CAW'((int'(ti) * NUM_TYPES + int'(tj)) * NCOEF);
   endfunction

   logic [3:0]  state_ff, state_in;
   logic [9:0]  ai_ff, ai_in, aj_ff, aj_in;
   logic [1:0]  ti_ff, ti_in, tj_ff, tj_in;
   logic        updj_ff, updj_in;
   logic signed [31:0] dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic [16:0] fac_ff, fac_in;
   logic [63:0] rsq_ff, rsq_in;
   logic signed [63:0] r2_ff, r2_in, r6_ff, r6_in, t_ff, t_in, fp_ff, fp_in;
   logic signed [63:0] px_ff, px_in, py_ff, py_in, pz_ff, pz_in, en_ff, en_in;
   logic signed [63:0] fx_ff, fx_in, fy_ff, fy_in, fz_ff, fz_in;
   logic        inr_ff, inr_in;
   logic signed [63:0] coef_ff [NCOEF];
   logic signed [63:0] coef_in [NCOEF];
   logic [2:0]  ck_ff, ck_in;
   logic [3:0]  opc_ff, opc_in;
   logic        side_ff, side_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic        energy_en_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic        rsp_user_ff, rsp_user_in;

   // Accumulator memories.
   logic [63:0] acc_x_mem [NUM_ATOMS];
   logic [63:0] acc_y_mem [NUM_ATOMS];
   logic [63:0] acc_z_mem [NUM_ATOMS];
   logic [63:0] rd_x_ff, rd_y_ff, rd_z_ff;
   logic          acc_we;
   logic [AW-1:0] acc_addr;
   logic signed [63:0] acc_wx, acc_wy, acc_wz;

   // Coefficient memory.
   logic [63:0]    coef_mem [CDEPTH];
   logic [63:0]    coef_rd_ff;
   logic           coef_we;
   logic [CAW-1:0] coef_waddr, coef_raddr;

   // Shared units.
   logic               mul_start, mul_done;
   logic signed [63:0] mul_a, mul_b, mul_q;
   logic [127:0]       mul_raw;
   logic               div_start, div_done;
   logic signed [63:0] div_q;

   // Request fields.
   logic        req_fire;
   logic [9:0]  f_ai, f_aj;
   logic [1:0]  f_ti, f_tj;
   logic        f_updj;
   logic [16:0] f_fac;
   logic [2:0]  f_sel;
   logic [63:0] f_cval;

   logic        ai_ok, aj_ok, side_en, in_cut;
   logic signed [63:0] fac64, op_sub;

   assign f_ai   = req_tdata[9:0];
   assign f_aj   = req_tdata[19:10];
   assign f_ti   = req_tdata[21:20];
   assign f_tj   = req_tdata[23:22];
   assign f_updj = req_tdata[24];
   assign f_fac  = req_tdata[137:121];
   assign f_sel  = req_tdata[140:138];
   assign f_cval = req_tdata[204:141];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign ai_ok   = (int'(ai_ff) < NUM_ATOMS);
   assign aj_ok   = (int'(aj_ff) < NUM_ATOMS);
   assign side_en = side_ff ? (updj_ff && aj_ok) : ai_ok;
   assign fac64   = {15'd0, fac_ff, 32'd0} >>> 16;
   assign in_cut  = (coef_ff[CSEL_CUTSQ] > 64'sd0) &&
                    ({16'd0, rsq_ff[63:16]} < coef_ff[CSEL_CUTSQ]);

   // Load writes go straight into the coefficient memory at transfer time.
   assign coef_waddr = coef_base(f_ti, f_tj) + CAW'(f_sel);
   assign coef_we    = req_fire && (req_tuser == CMD_LOAD) &&
                       (int'(f_ti) < NUM_TYPES) && (int'(f_tj) < NUM_TYPES) &&
                       (f_sel <= CSEL_CUTSQ);
   assign coef_raddr = coef_base(ti_ff, tj_ff) + CAW'((ck_ff > 3'd5) ? 3'd5 : ck_ff);

   // Operands of the shared multiplier per step.
   always_comb begin
      case (opc_ff)
         OP_RSQ_X: begin mul_a = 64'(dx_ff); mul_b = 64'(dx_ff); end
         OP_RSQ_Y: begin mul_a = 64'(dy_ff); mul_b = 64'(dy_ff); end
         OP_RSQ_Z: begin mul_a = 64'(dz_ff); mul_b = 64'(dz_ff); end
         OP_R4:    begin mul_a = r2_ff;  mul_b = r2_ff; end
         OP_R6:    begin mul_a = t_ff;   mul_b = r2_ff; end
         OP_F1:    begin mul_a = coef_ff[CSEL_LJ1]; mul_b = r6_ff; end
         OP_FLJ:   begin mul_a = r6_ff;  mul_b = t_ff; end
         OP_FFAC:  begin mul_a = fac64;  mul_b = t_ff; end
         OP_FP:    begin mul_a = t_ff;   mul_b = r2_ff; end
         OP_PX:    begin mul_a = 64'(dx_ff) <<< 8; mul_b = fp_ff; end
         OP_PY:    begin mul_a = 64'(dy_ff) <<< 8; mul_b = fp_ff; end
         OP_PZ:    begin mul_a = 64'(dz_ff) <<< 8; mul_b = fp_ff; end
         OP_E1:    begin mul_a = coef_ff[CSEL_LJ3]; mul_b = r6_ff; end
         OP_E2:    begin mul_a = r6_ff;  mul_b = t_ff; end
         default:  begin mul_a = fac64;  mul_b = t_ff; end
      endcase
   end

   // Subtrahend applied when a product is written back.
   always_comb begin
      case (opc_ff)
         OP_F1:   op_sub = coef_ff[CSEL_LJ2];
         OP_E1:   op_sub = coef_ff[CSEL_LJ4];
         OP_E2:   op_sub = coef_ff[CSEL_OFFS];
         default: op_sub = '0;
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      ai_in        = ai_ff;
      aj_in        = aj_ff;
      ti_in        = ti_ff;
      tj_in        = tj_ff;
      updj_in      = updj_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      dz_in        = dz_ff;
      fac_in       = fac_ff;
      rsq_in       = rsq_ff;
      r2_in        = r2_ff;
      r6_in        = r6_ff;
      t_in         = t_ff;
      fp_in        = fp_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pz_in        = pz_ff;
      en_in        = en_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      fz_in        = fz_ff;
      inr_in       = inr_ff;
      coef_in      = coef_ff;
      ck_in        = ck_ff;
      opc_in       = opc_ff;
      side_in      = side_ff;
      clr_cnt_in   = clr_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      mul_start    = 1'b0;
      div_start    = 1'b0;
      acc_we       = 1'b0;
      acc_addr     = side_ff ? AW'(aj_ff) : AW'(ai_ff);
      acc_wx       = '0;
      acc_wy       = '0;
      acc_wz       = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            acc_we     = 1'b1;
            acc_addr   = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(NUM_ATOMS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               ai_in   = f_ai;
               aj_in   = f_aj;
               ti_in   = f_ti;
               tj_in   = f_tj;
               updj_in = f_updj;
               dx_in   = req_tdata[56:25];
               dy_in   = req_tdata[88:57];
               dz_in   = req_tdata[120:89];
               fac_in  = f_fac;
               fx_in   = '0;
               fy_in   = '0;
               fz_in   = '0;
               en_in   = '0;
               inr_in  = 1'b0;
               side_in = 1'b0;
               ck_in   = 3'd0;
               unique case (req_tuser)
                  CMD_PAIR: begin
                     if ((int'(f_ti) < NUM_TYPES) && (int'(f_tj) < NUM_TYPES)) begin
                        state_in = ST_COEF;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  CMD_READ: state_in = ST_READ_RD;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_COEF: begin
            ck_in = ck_ff + 3'd1;
            if (ck_ff != 3'd0) coef_in[ck_ff - 3'd1] = coef_rd_ff;
            if (ck_ff == 3'(NCOEF)) begin
               opc_in   = OP_RSQ_X;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            mul_start = 1'b1;
            state_in  = ST_MWAIT;
         end
         ST_MWAIT: begin
            if (mul_done) begin
               opc_in   = opc_ff + 4'd1;
               state_in = ST_MUL;
               case (opc_ff)
                  OP_RSQ_X: rsq_in = mul_raw[63:0];
                  OP_RSQ_Y: rsq_in = rsq_ff + mul_raw[63:0];
                  OP_RSQ_Z: begin
                     rsq_in   = rsq_ff + mul_raw[63:0];
                     state_in = ST_CHECK;
                  end
                  OP_R6:    r6_in = mul_q;
                  OP_F1,
                  OP_E1,
                  OP_E2:    t_in = sat_sub(mul_q, op_sub);
                  OP_FP:    fp_in = mul_q;
                  OP_PX:    px_in = mul_q;
                  OP_PY:    py_in = mul_q;
                  OP_PZ: begin
                     pz_in = mul_q;
                     if (!energy_en_ff) state_in = ST_ACC_RD;
                  end
                  OP_EFAC: begin
                     en_in    = mul_q;
                     state_in = ST_ACC_RD;
                  end
                  default:  t_in = mul_q;
               endcase
            end
         end
         ST_CHECK: begin
            if (in_cut) begin
               inr_in    = 1'b1;
               div_start = 1'b1;
               state_in  = ST_DWAIT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DWAIT: begin
            if (div_done) begin
               r2_in    = div_q;
               opc_in   = OP_R4;
               state_in = ST_MUL;
            end
         end
         ST_ACC_RD: begin
            if (side_en) begin
               state_in = ST_ACC_WR;
            end else if (!side_ff) begin
               side_in = 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_ACC_WR: begin
            acc_we = 1'b1;
            if (side_ff) begin
               acc_wx   = sat_sub(rd_x_ff, px_ff);
               acc_wy   = sat_sub(rd_y_ff, py_ff);
               acc_wz   = sat_sub(rd_z_ff, pz_ff);
               state_in = ST_DONE;
            end else begin
               acc_wx   = sat_add(rd_x_ff, px_ff);
               acc_wy   = sat_add(rd_y_ff, py_ff);
               acc_wz   = sat_add(rd_z_ff, pz_ff);
               side_in  = 1'b1;
               state_in = ST_ACC_RD;
            end
         end
         ST_READ_RD: begin
            acc_addr = AW'(ai_ff);
            state_in = ai_ok ? ST_READ_WR : ST_DONE;
         end
         ST_READ_WR: begin
            acc_addr = AW'(ai_ff);
            acc_we   = 1'b1;
            fx_in    = rd_x_ff;
            fy_in    = rd_y_ff;
            fz_in    = rd_z_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {en_ff, fz_ff, fy_ff, fx_ff};
               rsp_user_in  = inr_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         energy_en_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) energy_en_ff <= csr_data[0];
      end
      ai_ff       <= ai_in;
      aj_ff       <= aj_in;
      ti_ff       <= ti_in;
      tj_ff       <= tj_in;
      updj_ff     <= updj_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      dz_ff       <= dz_in;
      fac_ff      <= fac_in;
      rsq_ff      <= rsq_in;
      r2_ff       <= r2_in;
      r6_ff       <= r6_in;
      t_ff        <= t_in;
      fp_ff       <= fp_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      pz_ff       <= pz_in;
      en_ff       <= en_in;
      fx_ff       <= fx_in;
      fy_ff       <= fy_in;
      fz_ff       <= fz_in;
      inr_ff      <= inr_in;
      coef_ff     <= coef_in;
      ck_ff       <= ck_in;
      opc_ff      <= opc_in;
      side_ff     <= side_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // Accumulator memories: one address, registered read.
   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_x_mem[acc_addr] <= acc_wx;
         acc_y_mem[acc_addr] <= acc_wy;
         acc_z_mem[acc_addr] <= acc_wz;
      end
      rd_x_ff <= acc_x_mem[acc_addr];
      rd_y_ff <= acc_y_mem[acc_addr];
      rd_z_ff <= acc_z_mem[acc_addr];
   end

   // Coefficient memory.
   always_ff @(posedge clock) begin
      if (coef_we) coef_mem[coef_waddr] <= f_cval;
      coef_rd_ff <= coef_mem[coef_raddr];
   end

   ljpf_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a_in  (mul_a),
      .b_in  (mul_b),
      .done  (mul_done),
      .raw   (mul_raw),
      .q     (mul_q)
   );

   ljpf_recip u_recip (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .d_in  (rsq_ff),
      .done  (div_done),
      .q     (div_q)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // No item is taken while the accumulators are being cleared.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("request taken during clearing pass");

   // The multiplier only finishes while the sequencer waits for it.
   a_mul_done_wait: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_MWAIT))
      else $error("multiplier result dropped");

   // Read-modify-write keeps the address of its read.
   a_rmw_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC_WR) |-> (acc_addr == $past(acc_addr)))
      else $error("accumulator write address moved");

   // A pair inside the cutoff reports zero force fields.
   a_inr_zero_force: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[191:0] == '0))
      else $error("force fields set on pair result");

   // The reciprocal is started only from the cutoff test, for a pair inside the cutoff.
   a_div_from_check: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (state_ff == ST_CHECK && inr_in))
      else $error("reciprocal started out of order");

endmodule

// File: rtl/ljpf_mul.sv
module ljpf_mul (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [63:0]  a_in,
   input  logic signed [63:0]  b_in,
   output logic                done,
   output logic [127:0]        raw,
   output logic signed [63:0]  q
);
   import ljpf_pkg::*;

   logic         busy_ff, busy_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic [63:0]  ma_ff, ma_in, mb_ff, mb_in;
   logic         neg_ff, neg_in;
   logic [63:0]  pp_ff, pp_in;
   logic [127:0] acc_ff, acc_in;
   logic signed [63:0] q_ff, q_in;
   logic         done_ff, done_in;

   logic [31:0]  pa, pb;
   logic [127:0] pp_sh;
   logic [63:0]  mag;
   logic         over;

   // Partial product selection: one 32x32 multiply per cycle.
   always_comb begin
      case (cnt_ff)
         3'd0:    begin pa = ma_ff[31:0];  pb = mb_ff[31:0];  end
         3'd1:    begin pa = ma_ff[31:0];  pb = mb_ff[63:32]; end
         3'd2:    begin pa = ma_ff[63:32]; pb = mb_ff[31:0];  end
         default: begin pa = ma_ff[63:32]; pb = mb_ff[63:32]; end
      endcase
      pp_in = {32'd0, pa} * {32'd0, pb};
   end

   // Alignment of the registered partial product from the previous cycle.
   always_comb begin
      case (cnt_ff)
         3'd1:    pp_sh = {64'd0, pp_ff};
         3'd2,
         3'd3:    pp_sh = {32'd0, pp_ff, 32'd0};
         default: pp_sh = {pp_ff, 64'd0};
      endcase
   end

   // Truncate toward zero and saturate to Q32.32.
   always_comb begin
      mag  = acc_ff[95:32];
      over = (acc_ff[127:96] != 32'd0) ||
             (neg_ff ? (mag > 64'h8000_0000_0000_0000) : (mag > 64'h7FFF_FFFF_FFFF_FFFF));
   end

   // Step control.
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      q_in    = q_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 3'd0;
         ma_in   = mag64(a_in);
         mb_in   = mag64(b_in);
         neg_in  = a_in[63] ^ b_in[63];
         acc_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff >= 3'd1 && cnt_ff <= 3'd4) begin
            acc_in = acc_ff + pp_sh;
         end
         if (cnt_ff == 3'd5) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (over) q_in = neg_ff ? Q_MIN : Q_MAX;
            else      q_in = neg_ff ? (64'd0 - mag) : mag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      ma_ff  <= ma_in;
      mb_ff  <= mb_in;
      neg_ff <= neg_in;
      pp_ff  <= pp_in;
      acc_ff <= acc_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign raw  = acc_ff;
   assign q    = q_ff;

endmodule

// File: rtl/ljpf_recip.sv
module ljpf_recip (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [63:0]        d_in,
   output logic               done,
   output logic signed [63:0] q
);
   import ljpf_pkg::*;

   logic        busy_ff, busy_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] d_ff, d_in_r;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] q_ff, q_in;
   logic        done_ff, done_in;

   logic [63:0] rem_sh;
   logic        take;

   // One restoring step per cycle over the dividend 2^80.
   always_comb begin
      rem_sh = {rem_ff[62:0], (cnt_ff == 7'd0)};
      take   = rem_ff[63] || (rem_sh >= d_ff);
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      d_in_r  = d_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      done_in = 1'b0;
      if (start) begin
         d_in_r = d_in;
         rem_in = '0;
         cnt_in = 7'd0;
         if (d_in <= RECIP_LIM) begin
            q_in    = Q_MAX;
            done_in = 1'b1;
         end else begin
            q_in    = '0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = take ? (rem_sh - d_ff) : rem_sh;
         q_in   = {q_ff[62:0], take};
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(RECIP_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 7'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      d_ff   <= d_in_r;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign q    = q_ff;

endmodule
